// ===== sv/multi_voice_sine_synth_macros.svh =====
// assertion helpers shared by the synth modules
// each expects clk_i and rst_ni in the enclosing module
`ifndef MULTI_VOICE_SINE_SYNTH_MACROS_SVH
`define MULTI_VOICE_SINE_SYNTH_MACROS_SVH

// same-cycle implication
`define MVSS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MVSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mvss_pkg.sv =====
`default_nettype none

package mvss_pkg;

  localparam int VOICE_COUNT      = 16;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int PHASE_BITS       = 32;
  localparam int QUEUE_DEPTH      = 2;

  localparam int NOTE_SPAN = 88;
  localparam logic [6:0] LOWEST_NOTE = 7'd21;
  localparam logic [6:0] NOTE_LAST   = 7'(NOTE_SPAN - 1);
  localparam logic [23:0] COUNT_MAX  = 24'hFF_FFFF;

  localparam logic [1:0] REQ_NOTE_ON = 2'd0;
  localparam logic [1:0] REQ_SAMPLE  = 2'd1;
  localparam logic [1:0] REQ_SWEEP   = 2'd2;

  typedef enum logic [1:0] {
    OP_NOTE_ON,
    OP_SAMPLE,
    OP_SWEEP,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  voice;
    logic [6:0]  note_code;
    logic [6:0]  velocity;
    logic [23:0] hold_samples;
    logic [7:0]  wave_kind;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               voice_busy;
    logic [4:0]         cleared_count;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [3:0]  voice;
    logic [6:0]  note_code;
    logic [6:0]  velocity;
    logic [23:0] hold_samples;
    logic [7:0]  wave_kind;
  } cmd_t;

  typedef struct packed {
    logic [23:0] duration;
    logic [6:0]  note_code;
    logic [6:0]  velocity;
    logic [7:0]  wave_kind;
    logic [23:0] count;
  } voice_entry_t;

  // note frequencies in milli-hertz, A0 upward
  localparam logic [21:0] FREQ_MILLI [NOTE_SPAN] = '{
    22'd27500, 22'd29135, 22'd30868, 22'd32703, 22'd34648, 22'd36708, 22'd38891,
    22'd41203, 22'd43654, 22'd46249, 22'd48999, 22'd51913, 22'd55000, 22'd58270,
    22'd61735, 22'd65406, 22'd69296, 22'd73416, 22'd77782, 22'd82407, 22'd87307,
    22'd92499, 22'd97999, 22'd103830, 22'd110000, 22'd116540, 22'd123470,
    22'd130810, 22'd138590, 22'd146830, 22'd155560, 22'd164810, 22'd174610,
    22'd185000, 22'd196000, 22'd207650, 22'd220000, 22'd233080, 22'd246940,
    22'd261630, 22'd277180, 22'd293670, 22'd311130, 22'd329630, 22'd349230,
    22'd369990, 22'd392000, 22'd415300, 22'd440000, 22'd466160, 22'd493880,
    22'd523250, 22'd554370, 22'd587330, 22'd622250, 22'd659260, 22'd698460,
    22'd739990, 22'd783990, 22'd830610, 22'd880000, 22'd932330, 22'd987770,
    22'd1046500, 22'd1108700, 22'd1174700, 22'd1244500, 22'd1318500,
    22'd1396900, 22'd1480000, 22'd1568000, 22'd1661200, 22'd1760000,
    22'd1864700, 22'd1975500, 22'd2093000, 22'd2217500, 22'd2349300,
    22'd2489000, 22'd2637000, 22'd2793000, 22'd2960000, 22'd3136000,
    22'd3322400, 22'd3520000, 22'd3729300, 22'd3951100, 22'd4186000
  };

  // phase increment per sample at 44.1 kHz, rounded; elaboration-time only
  function automatic logic [63:0] step_value(input logic [21:0] fm,
                                             input int unsigned pb);
    return ((64'(fm) << pb) + 64'd22050000) / 64'd44100000;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mvss_ram.sv =====
`default_nettype none

module mvss_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/mvss_front.sv =====
`default_nettype none

`include "multi_voice_sine_synth_macros.svh"

module mvss_front #(
  parameter int VoiceCount = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire mvss_pkg::in_item_t item_i,
  output logic                    cmd_valid_o,
  output mvss_pkg::cmd_t          cmd_o,
  input  wire logic               cmd_pop_i
);

  import mvss_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   fill_q, fill_d;
  cmd_t             cmd_new;
  logic             voice_ok;
  logic             push_ok;
  logic             pop_ok;

  assign full_o      = (fill_q == (PTR_W + 1)'(QUEUE_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push_ok     = push_i && !full_o;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;

  // out-of-range voices and the unused code both become no-ops
  assign voice_ok = ({5'd0, item_i.voice} < 9'(VoiceCount));

  always_comb begin
    cmd_new.voice        = item_i.voice;
    cmd_new.note_code    = item_i.note_code;
    cmd_new.velocity     = item_i.velocity;
    cmd_new.hold_samples = item_i.hold_samples;
    cmd_new.wave_kind    = item_i.wave_kind;
    case (item_i.req_type)
      REQ_NOTE_ON: cmd_new.op = voice_ok ? OP_NOTE_ON : OP_NONE;
      REQ_SAMPLE:  cmd_new.op = voice_ok ? OP_SAMPLE : OP_NONE;
      REQ_SWEEP:   cmd_new.op = OP_SWEEP;
      default:     cmd_new.op = OP_NONE;
    endcase
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_ok) begin
      wr_ptr_d = PTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop_ok) begin
      rd_ptr_d = PTR_W'(rd_ptr_q + 1'b1);
    end
    if (push_ok && !pop_ok) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

  `MVSS_ASSERT_IMPLIES(a_fill_range, 1'b1, fill_q <= (PTR_W + 1)'(QUEUE_DEPTH), "queue overfilled")
  `MVSS_ASSERT_IMPLIES(a_pop_nonempty, cmd_pop_i, fill_q != '0, "request popped from empty queue")

endmodule

`default_nettype wire

// ===== sv/mvss_back.sv =====
`default_nettype none

`include "multi_voice_sine_synth_macros.svh"

module mvss_back #(
  parameter int VoiceCount = 16,
  parameter int SineDepth  = 1024,
  parameter int PhaseBits  = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cmd_valid_i,
  input  wire mvss_pkg::cmd_t      cmd_i,
  output logic                     cmd_pop_o,
  input  wire logic                pop_i,
  output logic                     empty_o,
  output mvss_pkg::out_item_t      out_item_o
);

  import mvss_pkg::*;

  localparam int IDX_W   = $clog2(SineDepth);
  localparam int VIDX_W  = (VoiceCount > 1) ? $clog2(VoiceCount) : 1;
  localparam int ENTRY_W = $bits(voice_entry_t);

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] FULL_SCALE  = 32'd32767;
  localparam logic [31:0] ROUND_ADD   = 32'd63;

  // horner divisors, innermost first, then the velocity scale
  localparam logic [6:0] DIV_L0  = 7'd110;
  localparam logic [6:0] DIV_L1  = 7'd72;
  localparam logic [6:0] DIV_L2  = 7'd42;
  localparam logic [6:0] DIV_L3  = 7'd20;
  localparam logic [6:0] DIV_L4  = 7'd6;
  localparam logic [6:0] DIV_AMP = 7'd127;
  localparam logic [31:0] RECIP_L0  = 32'((64'd1 << 32) / 64'd110);
  localparam logic [31:0] RECIP_L1  = 32'((64'd1 << 32) / 64'd72);
  localparam logic [31:0] RECIP_L2  = 32'((64'd1 << 32) / 64'd42);
  localparam logic [31:0] RECIP_L3  = 32'((64'd1 << 32) / 64'd20);
  localparam logic [31:0] RECIP_L4  = 32'((64'd1 << 32) / 64'd6);
  localparam logic [31:0] RECIP_AMP = 32'((64'd1 << 32) / 64'd127);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_ENTRY    = 4'd1;
  localparam logic [3:0] ST_PHASE    = 4'd2;
  localparam logic [3:0] ST_X        = 4'd3;
  localparam logic [3:0] ST_X2       = 4'd4;
  localparam logic [3:0] ST_DIV_MUL  = 4'd5;
  localparam logic [3:0] ST_DIV_FIX  = 4'd6;
  localparam logic [3:0] ST_POLY_MUL = 4'd7;
  localparam logic [3:0] ST_S        = 4'd8;
  localparam logic [3:0] ST_MAG      = 4'd9;
  localparam logic [3:0] ST_AMP      = 4'd10;
  localparam logic [3:0] ST_SW_CHK   = 4'd11;
  localparam logic [3:0] ST_OUT      = 4'd12;

  logic [3:0]            state_q, state_d;
  logic [VoiceCount-1:0] valid_q, valid_d;
  logic                  rd_valid_q, rd_valid_d;
  logic [VIDX_W-1:0]     k_q, k_d;
  logic [4:0]            cleared_q, cleared_d;
  logic [2:0]            level_q, level_d;
  logic                  amp_q, amp_d;
  logic                  out_valid_q, out_valid_d;

  cmd_t                  cmd_q, cmd_d;
  logic [23:0]           cnt_q, cnt_d;
  logic [PhaseBits-1:0]  step_q, step_d;
  logic [6:0]            vel_q, vel_d;
  logic                  wave_one_q, wave_one_d;
  logic                  neg_q, neg_d;
  logic [30:0]           x_q, x_d;
  logic [31:0]           x2_q, x2_d;
  logic [30:0]           term_q, term_d;
  logic [31:0]           n_q, n_d;
  logic [63:0]           prod_q, prod_d;
  out_item_t             res_q, res_d;
  out_item_t             out_q, out_d;

  logic [PhaseBits-1:0]  step_rom [NOTE_SPAN];
  logic [VIDX_W-1:0]     rd_addr;
  logic [VIDX_W-1:0]     vidx;
  logic                  ram_we;
  voice_entry_t          ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;
  voice_entry_t          entry;
  logic [6:0]            note_k;
  logic [6:0]            note_off;

  logic [PhaseBits-1:0]       phase;
  logic [PhaseBits+IDX_W-1:0] phase_ext;
  logic [IDX_W-1:0]           tab_idx;
  logic [31:0]                turn;
  logic [30:0]                r_mir;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] div_n;
  logic [6:0]  div_d;
  logic [31:0] div_m;
  logic [31:0] q0;
  logic [39:0] rem;
  logic [31:0] quo;
  logic [46:0] mag_sum;
  logic [16:0] mag_raw;
  logic [14:0] mag;
  logic        hit;

  for (genvar gi = 0; gi < NOTE_SPAN; gi++) begin : g_step
    assign step_rom[gi] = PhaseBits'(step_value(FREQ_MILLI[gi], PhaseBits));
  end

  mvss_ram #(
    .Width (ENTRY_W),
    .Depth (VoiceCount)
  ) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (vidx),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign vidx       = VIDX_W'(cmd_q.voice);
  assign entry      = rd_valid_q ? voice_entry_t'(ram_rdata) : '0;
  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  // slots beyond the voice count never read as valid
  assign rd_valid_d = ({1'b0, rd_addr} < (VIDX_W + 1)'(VoiceCount)) ? valid_q[rd_addr] : 1'b0;

  always_comb begin
    note_off = entry.note_code - LOWEST_NOTE;
    if (entry.note_code < LOWEST_NOTE) begin
      note_k = '0;
    end else if (note_off > NOTE_LAST) begin
      note_k = NOTE_LAST;
    end else begin
      note_k = note_off;
    end
  end

  // table index, then quadrant and mirrored position within it
  always_comb begin
    phase     = prod_q[PhaseBits-1:0];
    phase_ext = {phase, {IDX_W{1'b0}}};
    tab_idx   = phase_ext[PhaseBits +: IDX_W];
    turn      = {tab_idx, {(32 - IDX_W){1'b0}}};
    r_mir     = turn[30] ? (Q30_ONE - {1'b0, turn[29:0]}) : {1'b0, turn[29:0]};
  end

  always_comb begin
    if (amp_q) begin
      div_d = DIV_AMP;
      div_m = RECIP_AMP;
    end else begin
      case (level_q)
        3'd0: begin
          div_d = DIV_L0;
          div_m = RECIP_L0;
        end
        3'd1: begin
          div_d = DIV_L1;
          div_m = RECIP_L1;
        end
        3'd2: begin
          div_d = DIV_L2;
          div_m = RECIP_L2;
        end
        3'd3: begin
          div_d = DIV_L3;
          div_m = RECIP_L3;
        end
        default: begin
          div_d = DIV_L4;
          div_m = RECIP_L4;
        end
      endcase
    end
  end

  // reciprocal estimate is low by at most one
  assign div_n = amp_q ? (prod_q[31:0] + ROUND_ADD) : prod_q[61:30];
  assign q0    = prod_q[63:32];
  assign rem   = 40'(n_q) - 40'(q0) * 40'(div_d);
  assign quo   = (rem >= 40'(div_d)) ? (q0 + 32'd1) : q0;

  assign mag_sum = prod_q[46:0] + 47'(32'h2000_0000);
  assign mag_raw = mag_sum[46:30];
  assign mag     = (mag_raw > 17'd32767) ? 15'd32767 : mag_raw[14:0];

  assign hit = (entry.duration != '0) && (entry.duration < entry.count);

  always_comb begin
    case (state_q)
      ST_PHASE: begin
        mul_a = 32'(cnt_q);
        mul_b = 32'(step_q);
      end
      ST_X: begin
        mul_a = 32'(r_mir);
        mul_b = HALF_PI_Q30;
      end
      ST_X2: begin
        // angle is still in the product register here
        mul_a = 32'(prod_q[60:30]);
        mul_b = 32'(prod_q[60:30]);
      end
      ST_DIV_MUL: begin
        mul_a = div_n;
        mul_b = div_m;
      end
      ST_POLY_MUL: begin
        mul_a = x2_q;
        mul_b = 32'(term_q);
      end
      ST_S: begin
        mul_a = 32'(x_q);
        mul_b = 32'(term_q);
      end
      ST_MAG: begin
        mul_a = 32'(prod_q[60:30]);
        mul_b = FULL_SCALE;
      end
      ST_AMP: begin
        mul_a = 32'(mag);
        mul_b = 32'(vel_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    k_d         = k_q;
    cleared_d   = cleared_q;
    level_d     = level_q;
    amp_d       = amp_q;
    out_valid_d = out_valid_q;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    step_d      = step_q;
    vel_d       = vel_q;
    wave_one_d  = wave_one_q;
    neg_d       = neg_q;
    x_d         = x_q;
    x2_d        = x2_q;
    term_d      = term_q;
    n_d         = n_q;
    prod_d      = prod_q;
    res_d       = res_q;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    rd_addr     = k_q;
    ram_we      = 1'b0;
    ram_wdata   = entry;

    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          res_d     = '0;
          amp_d     = 1'b0;
          case (cmd_i.op)
            OP_NOTE_ON, OP_SAMPLE: begin
              rd_addr = VIDX_W'(cmd_i.voice);
              state_d = ST_ENTRY;
            end
            OP_SWEEP: begin
              rd_addr   = '0;
              k_d       = '0;
              cleared_d = '0;
              state_d   = ST_SW_CHK;
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_ENTRY: begin
        ram_we        = 1'b1;
        valid_d[vidx] = 1'b1;
        if (cmd_q.op == OP_NOTE_ON) begin
          // a new note keeps the running sample count
          ram_wdata.duration  = cmd_q.hold_samples;
          ram_wdata.note_code = cmd_q.note_code;
          ram_wdata.velocity  = cmd_q.velocity;
          ram_wdata.wave_kind = cmd_q.wave_kind;
          res_d.voice_busy    = (cmd_q.hold_samples != '0);
          state_d             = ST_OUT;
        end else begin
          ram_wdata.count  = (entry.count < COUNT_MAX) ? (entry.count + 24'd1) : entry.count;
          cnt_d            = entry.count;
          step_d           = step_rom[note_k];
          vel_d            = entry.velocity;
          wave_one_d       = (entry.wave_kind == 8'd1);
          res_d.voice_busy = (entry.duration != '0);
          state_d          = ST_PHASE;
        end
      end
      ST_PHASE: begin
        prod_d  = mul_p;
        state_d = ST_X;
      end
      ST_X: begin
        neg_d   = turn[31];
        prod_d  = mul_p;
        state_d = ST_X2;
      end
      ST_X2: begin
        x_d     = prod_q[60:30];
        prod_d  = mul_p;
        level_d = '0;
        state_d = ST_DIV_MUL;
      end
      ST_DIV_MUL: begin
        n_d = div_n;
        if (!amp_q && (level_q == 3'd0)) begin
          x2_d = div_n;
        end
        prod_d  = mul_p;
        state_d = ST_DIV_FIX;
      end
      ST_DIV_FIX: begin
        if (amp_q) begin
          res_d.sample_value = !wave_one_q ? 16'sd0 :
                               neg_q ? (16'd0 - 16'(quo)) : 16'(quo);
          state_d = ST_OUT;
        end else begin
          term_d = Q30_ONE - 31'(quo);
          if (level_q == 3'd4) begin
            state_d = ST_S;
          end else begin
            level_d = level_q + 3'd1;
            state_d = ST_POLY_MUL;
          end
        end
      end
      ST_POLY_MUL: begin
        prod_d  = mul_p;
        state_d = ST_DIV_MUL;
      end
      ST_S: begin
        prod_d  = mul_p;
        state_d = ST_MAG;
      end
      ST_MAG: begin
        prod_d  = mul_p;
        state_d = ST_AMP;
      end
      ST_AMP: begin
        prod_d  = mul_p;
        amp_d   = 1'b1;
        state_d = ST_DIV_MUL;
      end
      ST_SW_CHK: begin
        // entry k is checked while k+1 is fetched
        rd_addr = VIDX_W'(k_q + 1'b1);
        if (hit) begin
          valid_d[k_q] = 1'b0;
        end
        cleared_d = cleared_q + 5'(hit);
        if (k_q == VIDX_W'(VoiceCount - 1)) begin
          res_d.cleared_count = cleared_q + 5'(hit);
          state_d             = ST_OUT;
        end else begin
          k_d = VIDX_W'(k_q + 1'b1);
        end
      end
      ST_OUT: begin
        if (!out_valid_q || pop_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      k_q         <= '0;
      cleared_q   <= '0;
      level_q     <= '0;
      amp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      rd_valid_q  <= rd_valid_d;
      k_q         <= k_d;
      cleared_q   <= cleared_d;
      level_q     <= level_d;
      amp_q       <= amp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    cnt_q      <= cnt_d;
    step_q     <= step_d;
    vel_q      <= vel_d;
    wave_one_q <= wave_one_d;
    neg_q      <= neg_d;
    x_q        <= x_d;
    x2_q       <= x2_d;
    term_q     <= term_d;
    n_q        <= n_d;
    prod_q     <= prod_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  `MVSS_ASSERT_IMPLIES(a_pop_in_idle, cmd_pop_o, (state_q == ST_IDLE) && cmd_valid_i, "request taken while busy")
  `MVSS_ASSERT_IMPLIES(a_write_in_entry, ram_we, state_q == ST_ENTRY, "voice table written outside update")
  `MVSS_ASSERT_NEXT(a_result_loaded, (state_q == ST_OUT) && (!out_valid_q || pop_i), out_valid_q && (state_q == ST_IDLE), "finished result not presented")

endmodule

`default_nettype wire

// ===== sv/multi_voice_sine_synth.sv =====
// Polyphonic sine oscillator with a table of voices.
// Input queue: drive in_item_i and raise push; the request is taken on a clock
// edge where push is high and full is low. Two requests can wait while the
// engine works. Output queue: while empty is low the oldest result is on
// out_item_o; raise pop to take it. Every request gives exactly one result.
// Requests are processed one at a time by a sequencer that shares a single
// 32x32 multiplier. A sample request passes through phase, angle, five
// polynomial steps each with a reciprocal divide, then velocity scaling; a
// cleanup sweep reads one voice per cycle from the voice table memory.
// The engine hands a finished result to a one-deep output register and starts
// the next queued request as soon as that register is free, so a stalled
// receiver holds up at most one more request before full rises.
// Reset empties both queues and marks every voice as cleared through per-voice
// valid bits; the block takes requests from the first cycle after reset.

`default_nettype none

module multi_voice_sine_synth #(
  parameter int VoiceCount = mvss_pkg::VOICE_COUNT,
  parameter int SineDepth  = mvss_pkg::SINE_TABLE_DEPTH,
  parameter int PhaseBits  = mvss_pkg::PHASE_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire mvss_pkg::in_item_t  in_item_i,
  output logic                     empty,
  input  wire logic                pop,
  output mvss_pkg::out_item_t      out_item_o
);

  import mvss_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  mvss_front #(
    .VoiceCount (VoiceCount)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  mvss_back #(
    .VoiceCount (VoiceCount),
    .SineDepth  (SineDepth),
    .PhaseBits  (PhaseBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mvss_pkg::*;

  localparam int VOICES = 16;
  localparam int TABLE_DEPTH = 1024;
  localparam int PHASE_W = 32;
  localparam logic [6:0] FIRST_KEY = 7'd21;
  localparam int LAST_KEY = 87;
  localparam logic [23:0] AGE_TOP = 24'hFF_FFFF;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int DRAIN_CYCLES = 40;

  // equal-tempered pitches in milli-hertz, A0 upward
  localparam int unsigned PITCH_MHZ [88] = '{
    27500, 29135, 30868, 32703, 34648, 36708, 38891, 41203, 43654, 46249,
    48999, 51913, 55000, 58270, 61735, 65406, 69296, 73416, 77782, 82407,
    87307, 92499, 97999, 103830, 110000, 116540, 123470, 130810, 138590,
    146830, 155560, 164810, 174610, 185000, 196000, 207650, 220000, 233080,
    246940, 261630, 277180, 293670, 311130, 329630, 349230, 369990, 392000,
    415300, 440000, 466160, 493880, 523250, 554370, 587330, 622250, 659260,
    698460, 739990, 783990, 830610, 880000, 932330, 987770, 1046500, 1108700,
    1174700, 1244500, 1318500, 1396900, 1480000, 1568000, 1661200, 1760000,
    1864700, 1975500, 2093000, 2217500, 2349300, 2489000, 2637000, 2793000,
    2960000, 3136000, 3322400, 3520000, 3729300, 3951100, 4186000
  };

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item_i;
  logic      empty;
  logic      pop;
  out_item_t out_item_o;

  multi_voice_sine_synth uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  // voice table as the testbench sees it
  logic [23:0] voice_len   [VOICES];
  logic [6:0]  voice_key   [VOICES];
  logic [6:0]  voice_amp   [VOICES];
  logic [7:0]  voice_shape [VOICES];
  logic [23:0] voice_age   [VOICES];

  out_item_t awaited_results [$];
  bit steady;
  int errors;
  int requests_sent;
  int results_checked;
  int sine_samples;
  int voices_swept;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic logic [63:0] phase_step(logic [6:0] key);
    int k;
    k = (key < FIRST_KEY) ? 0 : int'(key - FIRST_KEY);
    if (k > LAST_KEY) k = LAST_KEY;
    return ((64'(PITCH_MHZ[k]) << PHASE_W) + 64'd22050000) / 64'd44100000;
  endfunction

  // Q1.15 sine by a quarter-wave polynomial, truncating at every step but the final scaling, which rounds
  function automatic int sine_at(logic [31:0] phase);
    logic [63:0] tbl_index, turn, r, x, x2, term, s, mag;
    logic [1:0] quad;
    tbl_index = (64'(phase) * TABLE_DEPTH) >> PHASE_W;
    turn = (tbl_index << 32) / TABLE_DEPTH;
    quad = turn[31:30];
    r = {34'd0, turn[29:0]};
    if (quad[0]) r = ONE_Q30 - r;
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    term = ONE_Q30 - x2 / 64'd110;
    term = ONE_Q30 - ((x2 * term) >> 30) / 64'd72;
    term = ONE_Q30 - ((x2 * term) >> 30) / 64'd42;
    term = ONE_Q30 - ((x2 * term) >> 30) / 64'd20;
    term = ONE_Q30 - ((x2 * term) >> 30) / 64'd6;
    s = (x * term) >> 30;
    mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (mag > 64'd32767) mag = 64'd32767;
    return quad[1] ? -int'(mag[15:0]) : int'(mag[15:0]);
  endfunction

  // applies one request to the voice table and returns the synth output
  function automatic out_item_t synth_output_for(in_item_t r);
    out_item_t res;
    logic [31:0] phase;
    int s;
    int unsigned m, a, cleared;
    res = '0;
    cleared = 0;
    case (op_e'(r.req_type))
      OP_NOTE_ON: begin
        voice_len[r.voice] = r.hold_samples;
        voice_key[r.voice] = r.note_code;
        voice_amp[r.voice] = r.velocity;
        voice_shape[r.voice] = r.wave_kind;
        res.voice_busy = (r.hold_samples != 24'd0);
      end
      OP_SAMPLE: begin
        phase = 32'(64'(voice_age[r.voice]) * phase_step(voice_key[r.voice]));
        if (voice_shape[r.voice] == 8'd1) begin
          s = sine_at(phase);
          m = (s < 0) ? -s : s;
          a = (m * voice_amp[r.voice] + 63) / 127;
          res.sample_value = 16'((s < 0) ? -int'(a) : int'(a));
        end
        if (voice_age[r.voice] < AGE_TOP) voice_age[r.voice]++;
        res.voice_busy = (voice_len[r.voice] != 24'd0);
        if (res.sample_value != 16'sd0) sine_samples++;
      end
      OP_SWEEP: begin
        for (int k = 0; k < VOICES; k++) begin
          if (voice_len[k] != 24'd0 && voice_len[k] < voice_age[k]) begin
            voice_len[k] = '0;
            voice_key[k] = '0;
            voice_amp[k] = '0;
            voice_shape[k] = '0;
            voice_age[k] = '0;
            cleared++;
          end
        end
        res.cleared_count = 5'(cleared);
        voices_swept += cleared;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_item_t make_request(op_e op, logic [3:0] voice, logic [6:0] note,
                                            logic [6:0] vel, logic [23:0] hold,
                                            logic [7:0] wave);
    in_item_t r;
    r.req_type = op;
    r.voice = voice;
    r.note_code = note;
    r.velocity = vel;
    r.hold_samples = hold;
    r.wave_kind = wave;
    return r;
  endfunction

  // mostly playable traffic on a few busy voices, short notes so sweeps bite
  function automatic in_item_t random_request();
    in_item_t r;
    int unsigned pick;
    op_e op;
    pick = $urandom_range(0, 99);
    if (pick < 15) op = OP_NOTE_ON;
    else if (pick < 85) op = OP_SAMPLE;
    else if (pick < 95) op = OP_SWEEP;
    else op = OP_NONE;
    r.req_type = op;
    r.voice = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
    r.note_code = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(21, 108));
    r.velocity = 7'($urandom);
    r.hold_samples = ($urandom_range(0, 9) < 7) ? 24'($urandom_range(0, 60)) : 24'($urandom);
    r.wave_kind = ($urandom_range(0, 3) != 0) ? 8'd1 : 8'($urandom);
    return r;
  endfunction

  task automatic send_request(in_item_t r);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= r;
    do @(posedge clk_i); while (full);
    awaited_results.push_back(synth_output_for(r));
    requests_sent++;
  endtask

  task automatic wait_for_results();
    push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    results_checked++;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result sample %0d busy %0b cleared %0d", $time,
               $signed(got.sample_value), got.voice_busy, got.cleared_count);
      errors++;
      return;
    end
    want = awaited_results.pop_front();
    if (got.sample_value !== want.sample_value) begin
      $display("%0t: sample_value expected %0d got %0d", $time,
               $signed(want.sample_value), $signed(got.sample_value));
      errors++;
    end
    if (got.voice_busy !== want.voice_busy) begin
      $display("%0t: voice_busy expected %0b got %0b", $time, want.voice_busy, got.voice_busy);
      errors++;
    end
    if (got.cleared_count !== want.cleared_count) begin
      $display("%0t: cleared_count expected %0d got %0d", $time,
               want.cleared_count, got.cleared_count);
      errors++;
    end
  endtask

  initial begin : result_checker
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      check_result(out_item_o);
    end
  end

  // fresh table: silent samples, empty sweep, unused request with all ones
  task automatic test_idle_table();
    send_request(make_request(OP_SAMPLE, 4'd0, '0, '0, '0, '0));
    send_request(make_request(OP_SAMPLE, 4'd15, '0, '0, '0, '0));
    send_request(make_request(OP_SWEEP, 4'd0, '0, '0, '0, '0));
    send_request(make_request(OP_NONE, 4'd15, 7'h7F, 7'h7F, 24'hFF_FFFF, 8'hFF));
  endtask

  task automatic test_note_extremes();
    send_request(make_request(OP_NOTE_ON, 4'd0, 7'd21, 7'd127, 24'hFF_FFFF, 8'd1));
    repeat (3) send_request(make_request(OP_SAMPLE, 4'd0, '0, '0, '0, '0));
    send_request(make_request(OP_NOTE_ON, 4'd15, 7'd108, 7'd127, 24'd1, 8'd1));
    repeat (3) send_request(make_request(OP_SAMPLE, 4'd15, '0, '0, '0, '0));
  endtask

  // keys outside the piano range fall back to the nearest end
  task automatic test_note_clamp();
    send_request(make_request(OP_NOTE_ON, 4'd3, 7'd0, 7'd1, 24'd5, 8'd1));
    send_request(make_request(OP_SAMPLE, 4'd3, '0, '0, '0, '0));
    send_request(make_request(OP_NOTE_ON, 4'd4, 7'd127, 7'd64, 24'd5, 8'd1));
    repeat (2) send_request(make_request(OP_SAMPLE, 4'd4, '0, '0, '0, '0));
  endtask

  // non-sine waves are silent; a new note keeps the sample count
  task automatic test_silent_waves();
    send_request(make_request(OP_NOTE_ON, 4'd5, 7'd60, 7'd127, 24'd9, 8'd0));
    send_request(make_request(OP_SAMPLE, 4'd5, '0, '0, '0, '0));
    send_request(make_request(OP_NOTE_ON, 4'd5, 7'd60, 7'd127, 24'd9, 8'hFF));
    send_request(make_request(OP_SAMPLE, 4'd5, '0, '0, '0, '0));
  endtask

  task automatic test_inactive_voice();
    send_request(make_request(OP_NOTE_ON, 4'd6, 7'd69, 7'd127, 24'd0, 8'd1));
    repeat (2) send_request(make_request(OP_SAMPLE, 4'd6, '0, '0, '0, '0));
  endtask

  // voice 15 has outlived its one-sample duration
  task automatic test_sweep_clears();
    send_request(make_request(OP_SWEEP, 4'd0, '0, '0, '0, '0));
    send_request(make_request(OP_SAMPLE, 4'd15, '0, '0, '0, '0));
  endtask

  task automatic test_random_play(int count);
    repeat (count) send_request(random_request());
  endtask

  task automatic test_back_to_back(int count);
    steady = 1'b1;
    repeat (count) send_request(random_request());
    steady = 1'b0;
  endtask

  initial begin
    steady = 1'b0;
    errors = 0;
    requests_sent = 0;
    results_checked = 0;
    sine_samples = 0;
    voices_swept = 0;
    for (int k = 0; k < VOICES; k++) begin
      voice_len[k] = '0;
      voice_key[k] = '0;
      voice_amp[k] = '0;
      voice_shape[k] = '0;
      voice_age[k] = '0;
    end
    rst_ni <= 1'b0;
    push <= 1'b0;
    pop <= 1'b0;
    in_item_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_idle_table();
    test_note_extremes();
    test_note_clamp();
    test_silent_waves();
    test_inactive_voice();
    test_sweep_clears();
    wait_for_results();
    test_random_play(1250);
    test_back_to_back(70);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d requests sent and %0d results checked", requests_sent, results_checked);
    $display("%0d nonzero sine samples, %0d voices cleared by sweeps",
             sine_samples, voices_swept);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
